>>> hw/rtl/spitx_pkg.sv
// Shared types and constants for the SPI transmit master with frame FIFO.
// Holds command and register codes, status/control bit positions and the
// classified bus operation passed from the front end to the execution stage.
`default_nettype none

package spitx_pkg;

	localparam int DATA_W  = 16;
	localparam int FRAME_W = 8;
	localparam int CFG_W   = 3;

	// bus command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// register map
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_SIZE   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_FLAGS  = 3'd3;
	localparam logic [2:0] REG_TXDATA = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_BAUD  = 3'd0;
	localparam logic [2:0] CFG_FBITS = 3'd1;
	localparam logic [2:0] CFG_CPOL  = 3'd2;
	localparam logic [2:0] CFG_CPHA  = 3'd3;
	localparam logic [2:0] CFG_LSB   = 3'd4;

	// control, status and flag-clear bit positions
	localparam int BIT_ENABLE = 0;
	localparam int BIT_START  = 9;
	localparam int BIT_SSI    = 12;
	localparam int BIT_SPACE  = 1;
	localparam int BIT_END    = 3;
	localparam int BIT_FAULT  = 9;

	// one classified bus transaction
	typedef struct packed {
		logic              is_tick;
		logic              is_write;
		logic              is_read;
		logic [2:0]        sel;
		logic [DATA_W-1:0] wdata;
	} op_t;

endpackage

`default_nettype wire

>>> hw/rtl/spitx_front.sv
// Front end: accepts bus transactions, decodes the command and queues them.
// Uses spitx_pkg for the command codes and the op_t queue entry.
`default_nettype none

module spitx_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        command,
	input  wire logic [2:0]        reg_select,
	input  wire logic [15:0]       write_data,
	output logic                   head_valid,
	output spitx_pkg::op_t         head,
	input  wire logic              pop
);
	import spitx_pkg::*;

	op_t        ent_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	op_t        op_in;
	logic       push;

	// decode the command; an unused code becomes a no-op
	always_comb begin
		op_in.is_tick  = 1'b0;
		op_in.is_write = 1'b0;
		op_in.is_read  = 1'b0;
		op_in.sel      = reg_select;
		op_in.wdata    = write_data;
		case (command)
			CMD_TICK:  op_in.is_tick  = 1'b1;
			CMD_WRITE: op_in.is_write = 1'b1;
			CMD_READ:  op_in.is_read  = 1'b1;
			default:   ;
		endcase
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= op_in;
	end

	// queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/spitx_back.sv
// Execution stage: register file, frame FIFO, shift engine and output register.
// Uses spitx_pkg for register codes and bit positions; fed by spitx_front.
`default_nettype none

module spitx_back #(
	parameter int FIFO_DEPTH = 8,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire spitx_pkg::op_t                head,
	output logic                               pop,
	input  wire logic                          cfg_we,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [spitx_pkg::CFG_W-1:0]   cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [spitx_pkg::DATA_W-1:0]       read_data,
	output logic                               sck,
	output logic                               mosi
);
	import spitx_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic                 en;
		logic                 ssi;
		logic                 start;
		logic                 active;
		logic                 endf;
		logic                 fault;
		logic [CW-1:0]        count;
		logic [PW-1:0]        rp;
		logic [PW-1:0]        wp;
		logic [SIZE_BITS-1:0] frames;
		logic [FRAME_W-1:0]   shifter;
		logic [2:0]           bits;
		logic [7:0]           div;
		logic                 clk_lvl;
		logic                 data_lvl;
	} state_t;

	// configuration
	logic [2:0] baud_q;
	logic [2:0] fbits_q;
	logic       cpol_q;
	logic       cpha_q;
	logic       lsb_q;

	state_t             st_q;
	state_t             st_d;
	logic [FRAME_W-1:0] mem_q [FIFO_DEPTH];
	logic               mem_we;
	logic [PW-1:0]      mem_wa;
	logic [FRAME_W-1:0] mem_wd;
	logic [DATA_W-1:0]  rd_d;
	logic               fire;

	logic               out_valid_q;
	logic [DATA_W-1:0]  read_data_q;
	logic               sck_q;
	logic               mosi_q;

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// bit of the frame that goes out for a given count of bits still to come
	function automatic logic bit_at(logic [FRAME_W-1:0] sh, logic [2:0] bl,
			logic lsb, logic [2:0] fbm);
		logic [2:0] idx;
		idx = lsb ? (fbm - bl) : bl;
		return sh[idx];
	endfunction

	// disable: flush FIFO, stop the frame, park the clock at idle
	function automatic state_t disable_st(state_t s, logic pol);
		state_t r;
		r          = s;
		r.en       = 1'b0;
		r.start    = 1'b0;
		r.count    = '0;
		r.rp       = '0;
		r.wp       = '0;
		r.active   = 1'b0;
		r.bits     = '0;
		r.div      = '0;
		r.data_lvl = 1'b0;
		r.clk_lvl  = pol;
		return r;
	endfunction

	// mode fault check applied around every transaction
	function automatic state_t fault_st(state_t s, logic pol);
		state_t r;
		r = s;
		if (!r.ssi)
			r.fault = 1'b1;
		if (r.fault && r.en)
			r = disable_st(r, pol);
		return r;
	endfunction

	assign fire = head_valid && (!out_valid_q || !out_stall);
	assign pop  = fire;

	// next state for the transaction at the head of the queue
	always_comb begin
		state_t     st;
		logic [7:0] div_inc;
		logic [7:0] half;
		st      = fault_st(st_q, cpol_q);
		rd_d    = '0;
		mem_we  = 1'b0;
		mem_wa  = st_q.wp;
		mem_wd  = head.wdata[FRAME_W-1:0];
		div_inc = st.div + 8'd1;
		half    = 8'd1 << baud_q;

		if (head.is_tick && st.en && st.start) begin
			if (!st.active) begin
				// load the next frame if one is waiting
				if (st.count != '0) begin
					st.shifter = mem_q[st.rp];
					st.rp      = ptr_inc(st.rp);
					st.count   = st.count - CW'(1);
					st.bits    = fbits_q;
					st.active  = 1'b1;
					st.div     = '0;
					st.clk_lvl = cpol_q;
					if (!cpha_q)
						st.data_lvl = bit_at(st.shifter, st.bits, lsb_q, fbits_q);
				end
			end else if (div_inc < half) begin
				st.div = div_inc;
			end else begin
				st.div = '0;
				if (st.clk_lvl == cpol_q) begin
					// leading edge
					st.clk_lvl = ~st.clk_lvl;
					if (cpha_q)
						st.data_lvl = bit_at(st.shifter, st.bits, lsb_q, fbits_q);
				end else begin
					// trailing edge
					st.clk_lvl = ~st.clk_lvl;
					if (st.bits == 3'd0) begin
						st.active = 1'b0;
						if (st.frames <= SIZE_BITS'(1)) begin
							st.frames = '0;
							st.endf   = 1'b1;
							st.start  = 1'b0;
						end else begin
							st.frames = st.frames - SIZE_BITS'(1);
						end
					end else begin
						st.bits = st.bits - 3'd1;
						if (!cpha_q)
							st.data_lvl = bit_at(st.shifter, st.bits, lsb_q, fbits_q);
					end
				end
			end
		end else if (head.is_write) begin
			case (head.sel)
				REG_CTRL: begin
					st.ssi = head.wdata[BIT_SSI];
					st     = fault_st(st, cpol_q);
					if (!head.wdata[BIT_ENABLE]) begin
						if (st.en)
							st = disable_st(st, cpol_q);
					end else if (!st.fault) begin
						st.en = 1'b1;
					end
					if (head.wdata[BIT_START] && st.en && !st.start && st.frames != '0) begin
						st.start = 1'b1;
						st.endf  = 1'b0;
					end
				end
				REG_SIZE: st.frames = head.wdata[SIZE_BITS-1:0];
				REG_FLAGS: begin
					if (head.wdata[BIT_END])
						st.endf = 1'b0;
					if (head.wdata[BIT_FAULT] && st.ssi)
						st.fault = 1'b0;
				end
				REG_TXDATA: begin
					if (st.en && st.count < CW'(FIFO_DEPTH)) begin
						mem_we   = 1'b1;
						mem_wa   = st.wp;
						st.wp    = ptr_inc(st.wp);
						st.count = st.count + CW'(1);
					end
				end
				default: ;
			endcase
		end else if (head.is_read) begin
			case (head.sel)
				REG_CTRL: begin
					rd_d[BIT_ENABLE] = st.en;
					rd_d[BIT_START]  = st.start;
					rd_d[BIT_SSI]    = st.ssi;
				end
				REG_SIZE: rd_d = DATA_W'(st.frames);
				REG_STATUS: begin
					rd_d[BIT_SPACE] = (st.count < CW'(FIFO_DEPTH));
					rd_d[BIT_END]   = st.endf;
					rd_d[BIT_FAULT] = st.fault;
				end
				default: rd_d = '0;
			endcase
		end

		st = fault_st(st, cpol_q);
		if (!st.active)
			st.clk_lvl = cpol_q;
		st_d = st;
	end

	// frame storage, contents undefined until written
	always_ff @(posedge clk) begin
		if (fire && mem_we)
			mem_q[mem_wa] <= mem_wd;
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (fire)
			st_q <= st_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_q  <= 3'd0;
			fbits_q <= 3'd7;
			cpol_q  <= 1'b0;
			cpha_q  <= 1'b0;
			lsb_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAUD:  baud_q  <= cfg_data;
				CFG_FBITS: fbits_q <= cfg_data;
				CFG_CPOL:  cpol_q  <= cfg_data[0];
				CFG_CPHA:  cpha_q  <= cfg_data[0];
				CFG_LSB:   lsb_q   <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= rd_d;
			sck_q       <= st_d.clk_lvl;
			mosi_q      <= st_d.data_lvl;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign sck       = sck_q;
	assign mosi      = mosi_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count <= CW'(FIFO_DEPTH))
		else $error("frame FIFO count exceeds depth");
	a_flush_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.en |-> st_q.count == '0)
		else $error("frames held while disabled");
	a_fault_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fault |-> !st_q.en)
		else $error("enabled during mode fault");
	a_start_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.start |-> st_q.en)
		else $error("transfer started while disabled");
	a_frame_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active |-> st_q.start)
		else $error("frame shifting outside a transfer");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/spi_tx_master_with_fifo_core.sv
// SPI transmit master with frame FIFO, register front end and shift engine.
//
// Input channel (in_valid/in_stall) carries one bus transaction per item:
// a clock tick, a register write or a register read. Output channel
// (out_valid/out_stall) returns one result per transaction: read data (zero
// unless a read), and the sck and mosi levels after that transaction.
// Configuration (baud exponent, frame bits, polarity, phase, bit order) is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// no transaction is pending; the block does not enforce this. An accepted
// transaction is written into the queue, and its result is registered in the
// output register once execution takes it; throughput is one transaction per
// cycle while the receiver does not stall. A two-entry queue separates the
// decoder from execution and an output register separates execution from the
// receiver, so input is taken while a result waits. When the receiver stalls,
// the result holds, execution pauses and the queue fills; in_stall rises once
// both entries are in use. Reset clears control state, pointers and counts at
// once; no clearing pass runs. FIFO frame contents are undefined until written.
`default_nettype none

module spi_tx_master_with_fifo_core #(
	parameter int FIFO_DEPTH = 8,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [2:0]  reg_select,
	input  wire logic [15:0] write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      read_data,
	output logic             sck,
	output logic             mosi,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [2:0]  cfg_data
);
	import spitx_pkg::*;

	logic head_valid;
	op_t  head;
	logic pop;

	// decode and queue
	spitx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.reg_select (reg_select),
		.write_data (write_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// execution and result register
	spitx_back #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.SIZE_BITS  (SIZE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.sck        (sck),
		.mosi       (mosi)
	);

endmodule

`default_nettype wire

>>> test/spi_tx_master_with_fifo_core_test.sv
// Self-checking bench for spi_tx_master_with_fifo_core: a shadow of the register file
// and shift engine predicts read data, sck and mosi for every transaction.
// Depends on spitx_pkg and the core; clocked driver and monitor, random handshake gaps.
module spi_tx_master_with_fifo_core_test;
	import spitx_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int QUEUE_DEPTH = 8;
	localparam int CYCLE_LIMIT = 20000;
	localparam int CALM_FROM   = 200;
	localparam int CALM_TO     = 500;
	localparam int PRINT_CAP   = 100;

	// codes the package leaves unnamed
	localparam logic [1:0] CMD_NONE  = 2'd3;
	localparam logic [2:0] REG_VOID5 = 3'd5;
	localparam logic [2:0] REG_VOID7 = 3'd7;

	localparam logic [15:0] CTL_EN    = 16'd1 << BIT_ENABLE;
	localparam logic [15:0] CTL_GO    = 16'd1 << BIT_START;
	localparam logic [15:0] CTL_SSI   = 16'd1 << BIT_SSI;
	localparam logic [15:0] CLR_END   = 16'd1 << BIT_END;
	localparam logic [15:0] CLR_FAULT = 16'd1 << BIT_FAULT;

	typedef struct {
		logic [1:0]  cmd;
		logic [2:0]  sel;
		logic [15:0] wdata;
	} bus_txn_t;

	typedef struct {
		logic [15:0] rdata;
		logic        sck;
		logic        mosi;
	} pin_reply_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  command    = CMD_TICK;
	logic [2:0]  reg_select = REG_CTRL;
	logic [15:0] write_data = 16'h0000;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [15:0] read_data;
	logic        sck;
	logic        mosi;
	logic        cfg_we     = 1'b0;
	logic [2:0]  cfg_index  = CFG_BAUD;
	logic [2:0]  cfg_data   = 3'd0;

	bus_txn_t   pending_txns[$];
	pin_reply_t expected_replies[$];
	int         error_count = 0;
	int         cycle_count = 0;
	int         phase_items = 0;
	logic [2:0] cur_baud    = 3'd0;
	logic [2:0] cur_fbits   = 3'd7;

	// shadow configuration
	logic [2:0] sh_baud, sh_fbits;
	logic       sh_cpol, sh_cpha, sh_lsb;
	// shadow engine state
	logic [7:0]  sh_fifo [QUEUE_DEPTH];
	int          sh_count;
	logic [2:0]  sh_rd, sh_wr;
	logic [15:0] sh_frames;
	logic [7:0]  sh_shift;
	logic [2:0]  sh_bits;
	int          sh_div;
	logic        sh_sck, sh_mosi;
	logic        sh_en, sh_ssi, sh_start, sh_active, sh_end, sh_fault;

	always #HALF_PERIOD clk = ~clk;

	spi_tx_master_with_fifo_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.reg_select (reg_select),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.sck        (sck),
		.mosi       (mosi),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ---------------------------------------------------------------- shadow model

	function automatic void shadow_reset();
		sh_baud   = 3'd0;
		sh_fbits  = 3'd7;
		sh_cpol   = 1'b0;
		sh_cpha   = 1'b0;
		sh_lsb    = 1'b0;
		foreach (sh_fifo[i]) sh_fifo[i] = 8'h00;
		sh_count  = 0;
		sh_rd     = 3'd0;
		sh_wr     = 3'd0;
		sh_frames = 16'h0000;
		sh_shift  = 8'h00;
		sh_bits   = 3'd0;
		sh_div    = 0;
		sh_sck    = 1'b0;
		sh_mosi   = 1'b0;
		sh_en     = 1'b0;
		sh_ssi    = 1'b0;
		sh_start  = 1'b0;
		sh_active = 1'b0;
		sh_end    = 1'b0;
		sh_fault  = 1'b0;
	endfunction

	function automatic void shadow_config(input logic [2:0] idx, input logic [2:0] val);
		case (idx)
			CFG_BAUD:  sh_baud  = val;
			CFG_FBITS: sh_fbits = val;
			CFG_CPOL:  sh_cpol  = val[0];
			CFG_CPHA:  sh_cpha  = val[0];
			CFG_LSB:   sh_lsb   = val[0];
			default: ;
		endcase
	endfunction

	// bit of the shifter that goes out now, counted from the chosen end
	function automatic logic shadow_bit();
		logic [2:0] pos;
		pos = sh_lsb ? (sh_fbits - sh_bits) : sh_bits;
		return sh_shift[pos];
	endfunction

	function automatic void shadow_disable();
		sh_en     = 1'b0;
		sh_start  = 1'b0;
		sh_count  = 0;
		sh_rd     = 3'd0;
		sh_wr     = 3'd0;
		sh_active = 1'b0;
		sh_bits   = 3'd0;
		sh_div    = 0;
		sh_mosi   = 1'b0;
		sh_sck    = sh_cpol;
	endfunction

	// mode fault: no internal slave select latches the fault and kills enable
	function automatic void shadow_fault_check();
		if (!sh_ssi)
			sh_fault = 1'b1;
		if (sh_fault && sh_en)
			shadow_disable();
	endfunction

	function automatic void shadow_tick();
		if (!sh_en || !sh_start)
			return;
		// frame load, one tick after the previous frame ended
		if (!sh_active) begin
			if (sh_count == 0)
				return;
			sh_shift  = sh_fifo[sh_rd];
			sh_rd     = sh_rd + 3'd1;
			sh_count  = sh_count - 1;
			sh_bits   = sh_fbits;
			sh_active = 1'b1;
			sh_div    = 0;
			sh_sck    = sh_cpol;
			if (!sh_cpha)
				sh_mosi = shadow_bit();
			return;
		end
		sh_div = sh_div + 1;
		if (sh_div < (1 << sh_baud))
			return;
		sh_div = 0;
		if (sh_sck == sh_cpol) begin
			// leading edge
			sh_sck = ~sh_sck;
			if (sh_cpha)
				sh_mosi = shadow_bit();
		end else begin
			// trailing edge
			sh_sck = ~sh_sck;
			if (sh_bits == 3'd0) begin
				sh_active = 1'b0;
				if (sh_frames <= 16'd1) begin
					sh_frames = 16'h0000;
					sh_end    = 1'b1;
					sh_start  = 1'b0;
				end else begin
					sh_frames = sh_frames - 16'd1;
				end
			end else begin
				sh_bits = sh_bits - 3'd1;
				if (!sh_cpha)
					sh_mosi = shadow_bit();
			end
		end
	endfunction

	function automatic void shadow_write(input logic [2:0] sel, input logic [15:0] wd);
		case (sel)
			REG_CTRL: begin
				sh_ssi = wd[BIT_SSI];
				shadow_fault_check();
				if (!wd[BIT_ENABLE]) begin
					if (sh_en)
						shadow_disable();
				end else if (!sh_fault) begin
					sh_en = 1'b1;
				end
				if (wd[BIT_START] && sh_en && !sh_start && sh_frames != 16'h0000) begin
					sh_start = 1'b1;
					sh_end   = 1'b0;
				end
			end
			REG_SIZE: sh_frames = wd;
			REG_FLAGS: begin
				if (wd[BIT_END])
					sh_end = 1'b0;
				if (wd[BIT_FAULT] && sh_ssi)
					sh_fault = 1'b0;
			end
			REG_TXDATA: begin
				if (sh_en && sh_count < QUEUE_DEPTH) begin
					sh_fifo[sh_wr] = wd[7:0];
					sh_wr          = sh_wr + 3'd1;
					sh_count       = sh_count + 1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] shadow_read(input logic [2:0] sel);
		logic [15:0] r;
		r = 16'h0000;
		case (sel)
			REG_CTRL: begin
				r[BIT_ENABLE] = sh_en;
				r[BIT_START]  = sh_start;
				r[BIT_SSI]    = sh_ssi;
			end
			REG_SIZE: r = sh_frames;
			REG_STATUS: begin
				r[BIT_SPACE] = (sh_count < QUEUE_DEPTH);
				r[BIT_END]   = sh_end;
				r[BIT_FAULT] = sh_fault;
			end
			default: ;
		endcase
		return r;
	endfunction

	// one transaction through the shadow; returns the reply it should produce
	function automatic pin_reply_t shadow_transaction(input logic [1:0] cmd,
			input logic [2:0] sel, input logic [15:0] wd);
		pin_reply_t rep;
		rep.rdata = 16'h0000;
		shadow_fault_check();
		case (cmd)
			CMD_TICK:  shadow_tick();
			CMD_WRITE: shadow_write(sel, wd);
			CMD_READ:  rep.rdata = shadow_read(sel);
			default: ;
		endcase
		shadow_fault_check();
		if (!sh_active)
			sh_sck = sh_cpol;
		rep.sck  = sh_sck;
		rep.mosi = sh_mosi;
		return rep;
	endfunction

	// ---------------------------------------------------------------- helpers

	function automatic logic idle_now();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
			return 1'b0;
		return ($urandom_range(99) < 24);
	endfunction

	task automatic note_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic void queue_txn(input logic [1:0] cmd, input logic [2:0] sel,
			input logic [15:0] wd);
		bus_txn_t t;
		t.cmd   = cmd;
		t.sel   = sel;
		t.wdata = wd;
		pending_txns.push_back(t);
		phase_items++;
	endfunction

	// control word with the given bits and random don't-care bits elsewhere
	function automatic logic [15:0] ctl_word(input logic [15:0] bits);
		return (16'($urandom) & ~(CTL_SSI | CTL_EN | CTL_GO)) | bits;
	endfunction

	task automatic queue_directed();
		queue_txn(CMD_READ, REG_STATUS, 16'h0000);
		queue_txn(CMD_WRITE, REG_TXDATA, 16'hFFFF);      // disabled: dropped
		queue_txn(CMD_WRITE, REG_CTRL, CTL_EN);          // no slave select: fault
		queue_txn(CMD_WRITE, REG_CTRL, CTL_SSI);
		queue_txn(CMD_WRITE, REG_FLAGS, 16'hFFFF);
		queue_txn(CMD_WRITE, REG_CTRL, CTL_SSI | CTL_EN | CTL_GO);  // size zero: no start
		queue_txn(CMD_WRITE, REG_SIZE, 16'hFFFF);
		queue_txn(CMD_READ, REG_SIZE, 16'h0000);
		queue_txn(CMD_WRITE, REG_SIZE, 16'd2);
		queue_txn(CMD_WRITE, REG_CTRL, CTL_SSI | CTL_EN | CTL_GO);
		queue_txn(CMD_TICK, REG_CTRL, 16'h0000);         // underrun: sck stays idle
		// fill the FIFO, the last write finds it full
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			queue_txn(CMD_WRITE, REG_TXDATA, 16'h5A00 ^ 16'(i * 37));
		queue_txn(CMD_READ, REG_STATUS, 16'hFFFF);
		queue_txn(CMD_NONE, REG_VOID7, 16'hFFFF);
		queue_txn(CMD_READ, REG_VOID5, 16'hFFFF);
		queue_txn(CMD_WRITE, REG_VOID7, 16'hFFFF);
		queue_txn(CMD_WRITE, REG_STATUS, 16'hFFFF);
	endtask

	// a well-formed transfer with random content, now and then broken on purpose
	task automatic queue_transfer();
		int frames;
		int per_frame;
		int ticks;
		int skip;
		int roll;
		frames = $urandom_range(1, 3);
		skip   = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
		queue_txn(CMD_WRITE, REG_CTRL, ctl_word(CTL_SSI));
		if (skip != 1)
			queue_txn(CMD_WRITE, REG_FLAGS, 16'($urandom) | CLR_END | CLR_FAULT);
		if (skip != 2)
			queue_txn(CMD_WRITE, REG_SIZE, 16'(frames));
		if (skip != 3)
			queue_txn(CMD_WRITE, REG_CTRL, ctl_word(CTL_SSI | CTL_EN | CTL_GO));
		repeat (frames + $urandom_range(0, 1))
			queue_txn(CMD_WRITE, REG_TXDATA, 16'($urandom));
		per_frame = 2 + (int'(cur_fbits) + 1) * 2 * (1 << cur_baud);
		ticks     = frames * per_frame + $urandom_range(0, 6);
		repeat (ticks) begin
			roll = $urandom_range(999);
			if (roll < 60)
				queue_txn(CMD_READ, 3'($urandom_range(0, 7)), 16'($urandom));
			else if (roll < 80)
				queue_txn(CMD_WRITE, REG_TXDATA, 16'($urandom));
			else if (roll < 86)
				queue_txn(CMD_WRITE, REG_SIZE, 16'($urandom_range(0, 3)));
			else if (roll < 89)
				queue_txn(CMD_WRITE, REG_CTRL, 16'($urandom));
			queue_txn(CMD_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
		end
		if ($urandom_range(1) == 1)
			queue_txn(CMD_WRITE, REG_CTRL, ctl_word(CTL_SSI));
		queue_txn(CMD_READ, REG_STATUS, 16'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_txns.size() != 0 || in_valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// program the five settings, then run directed and random traffic
	task automatic run_phase(input logic [2:0] baud, input logic [2:0] fbits,
			input logic cpol, input logic cpha, input logic lsb,
			input logic directed, input int budget);
		logic [2:0] idx  [5];
		logic [2:0] vals [5];
		idx  = '{CFG_BAUD, CFG_FBITS, CFG_CPOL, CFG_CPHA, CFG_LSB};
		vals = '{baud, fbits, {2'b00, cpol}, {2'b00, cpha}, {2'b00, lsb}};
		cur_baud  = baud;
		cur_fbits = fbits;
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		phase_items = 0;
		if (directed)
			queue_directed();
		while (phase_items < budget) begin
			if ($urandom_range(99) < 75)
				queue_transfer();
			else
				repeat ($urandom_range(1, 6))
					queue_txn(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						16'($urandom));
		end
		// leave the block disabled so no frame is in flight across the setting change
		queue_txn(CMD_WRITE, REG_CTRL, ctl_word(CTL_SSI));
		wait_drained();
	endtask

	// ---------------------------------------------------------------- driver

	// predicts each accepted transaction, then offers the next pending one
	always @(posedge clk) begin : drive_bus
		bus_txn_t next_txn;
		logic     send;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_replies.push_back(shadow_transaction(command, reg_select, write_data));
			if (cfg_we)
				shadow_config(cfg_index, cfg_data);
			if (!in_valid || !in_stall) begin
				send = (pending_txns.size() != 0) && !idle_now();
				if (send) begin
					next_txn = pending_txns.pop_front();
					command    <= next_txn.cmd;
					reg_select <= next_txn.sel;
					write_data <= next_txn.wdata;
				end
				in_valid <= send;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : watch_pins
		pin_reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					note_mismatch("reply with no transaction outstanding");
				end else begin
					want = expected_replies.pop_front();
					if (read_data !== want.rdata)
						note_mismatch($sformatf("read_data %h, expected %h",
							read_data, want.rdata));
					if (sck !== want.sck)
						note_mismatch($sformatf("sck %b, expected %b", sck, want.sck));
					if (mosi !== want.mosi)
						note_mismatch($sformatf("mosi %b, expected %b", mosi, want.mosi));
				end
			end
			out_stall <= idle_now();
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("spi_tx_master_with_fifo_core verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		shadow_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		run_phase(3'd0, 3'd7, 1'b0, 1'b0, 1'b0, 1'b1, 40);
		run_phase(3'd1, 3'd7, 1'b1, 1'b0, 1'b1, 1'b0, 30);
		run_phase(3'd2, 3'd3, 1'b0, 1'b1, 1'b0, 1'b0, 30);
		run_phase(3'd0, 3'd1, 1'b1, 1'b1, 1'b1, 1'b0, 30);
		run_phase(3'd0, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 30);
		// slow clock with the shortest frame
		run_phase(3'd4, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 10);
		repeat (2)
			run_phase(3'($urandom_range(0, 2)), 3'($urandom_range(3, 7)), 1'($urandom),
				1'($urandom), 1'($urandom), 1'b0, 30);
		if (error_count == 0)
			$display("spi_tx_master_with_fifo_core verification clean");
		else
			$display("spi_tx_master_with_fifo_core verification failed");
		$finish;
	end

endmodule
